>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/rvdec_pkg.sv
// Types, operation codes, opcodes and funct lookups for the RV32I decoder.
`default_nettype none

package rvdec_pkg;

    typedef logic [5:0] t_op;

    localparam t_op OP_UNKNOWN = 6'd0;
    localparam t_op OP_HALT    = 6'd1;
    localparam t_op OP_NOP     = 6'd2;
    localparam t_op OP_ADD     = 6'd3;
    localparam t_op OP_SUB     = 6'd4;
    localparam t_op OP_AND     = 6'd5;
    localparam t_op OP_OR      = 6'd6;
    localparam t_op OP_XOR     = 6'd7;
    localparam t_op OP_SLL     = 6'd8;
    localparam t_op OP_SRL     = 6'd9;
    localparam t_op OP_SRA     = 6'd10;
    localparam t_op OP_SLT     = 6'd11;
    localparam t_op OP_SLTU    = 6'd12;
    localparam t_op OP_ADDI    = 6'd13;
    localparam t_op OP_ANDI    = 6'd14;
    localparam t_op OP_ORI     = 6'd15;
    localparam t_op OP_XORI    = 6'd16;
    localparam t_op OP_SLLI    = 6'd17;
    localparam t_op OP_SRLI    = 6'd18;
    localparam t_op OP_SRAI    = 6'd19;
    localparam t_op OP_SLTI    = 6'd20;
    localparam t_op OP_SLTIU   = 6'd21;
    localparam t_op OP_LB      = 6'd22;
    localparam t_op OP_LBU     = 6'd23;
    localparam t_op OP_LH      = 6'd24;
    localparam t_op OP_LHU     = 6'd25;
    localparam t_op OP_LW      = 6'd26;
    localparam t_op OP_SB      = 6'd27;
    localparam t_op OP_SH      = 6'd28;
    localparam t_op OP_SW      = 6'd29;
    localparam t_op OP_BEQ     = 6'd30;
    localparam t_op OP_BGE     = 6'd31;
    localparam t_op OP_BGEU    = 6'd32;
    localparam t_op OP_BLT     = 6'd33;
    localparam t_op OP_BLTU    = 6'd34;
    localparam t_op OP_BNE     = 6'd35;
    localparam t_op OP_JAL     = 6'd36;
    localparam t_op OP_JALR    = 6'd37;
    localparam t_op OP_AUIPC   = 6'd38;
    localparam t_op OP_LUI     = 6'd39;

    localparam logic [6:0] OPC_R      = 7'b0110011;
    localparam logic [6:0] OPC_IARITH = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SL  = 3'd1;
    localparam logic [2:0] F3_SR  = 3'd5;

    localparam logic [31:0] HALT_WORD = 32'h0ff00513;
    localparam logic [31:0] HALT_IMM  = 32'd255;
    localparam logic [31:0] U_MASK    = 32'hFFFFF000;

    typedef struct packed {
        t_op                op_type;
        logic [6:0]         major_opcode;
        logic [6:0]         upper_funct;
        logic [2:0]         minor_funct;
        logic [4:0]         dest_reg;
        logic [4:0]         src_reg_a;
        logic [4:0]         src_reg_b;
        logic signed [31:0] immediate;
    } t_dec_result;

    function automatic t_op r_base_op(input logic [2:0] f3);
        t_op op;
        case (f3)
            3'd0:    op = OP_ADD;
            3'd1:    op = OP_SLL;
            3'd2:    op = OP_SLT;
            3'd3:    op = OP_SLTU;
            3'd4:    op = OP_XOR;
            3'd5:    op = OP_SRL;
            3'd6:    op = OP_OR;
            default: op = OP_AND;
        endcase
        return op;
    endfunction

    function automatic t_op iarith_op(input logic [2:0] f3);
        t_op op;
        case (f3)
            3'd0:    op = OP_ADDI;
            3'd1:    op = OP_SLLI;
            3'd2:    op = OP_SLTI;
            3'd3:    op = OP_SLTIU;
            3'd4:    op = OP_XORI;
            3'd5:    op = OP_SRLI;
            3'd6:    op = OP_ORI;
            default: op = OP_ANDI;
        endcase
        return op;
    endfunction

    function automatic t_op load_op(input logic [2:0] f3);
        t_op op;
        case (f3)
            3'd0:    op = OP_LB;
            3'd1:    op = OP_LH;
            3'd2:    op = OP_LW;
            3'd4:    op = OP_LBU;
            3'd5:    op = OP_LHU;
            default: op = OP_UNKNOWN;
        endcase
        return op;
    endfunction

    function automatic t_op store_op(input logic [2:0] f3);
        t_op op;
        case (f3)
            3'd0:    op = OP_SB;
            3'd1:    op = OP_SH;
            3'd2:    op = OP_SW;
            default: op = OP_UNKNOWN;
        endcase
        return op;
    endfunction

    function automatic t_op branch_op(input logic [2:0] f3);
        t_op op;
        case (f3)
            3'd0:    op = OP_BEQ;
            3'd1:    op = OP_BNE;
            3'd4:    op = OP_BLT;
            3'd5:    op = OP_BGE;
            3'd6:    op = OP_BLTU;
            3'd7:    op = OP_BGEU;
            default: op = OP_UNKNOWN;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

>>> sv/rv32i_instruction_decoder.sv
// Top level of the RV32I decoder: input register, decode, result register.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+----------------------------------
//  instr in | i_instr_valid / o_instr_ready  | i_instr_word
//  result   | o_res_valid / i_res_ready      | o_op_type .. o_immediate
//
// One item per cycle sustained while i_res_ready stays high; the word is held in the input
// register, decoded combinationally and captured in the result register, which drives
// o_res_valid.
// i_rst_n (synchronous, active low) empties both stages.
// A stall on the result side holds the result register; the input register
// keeps accepting until it too is full, so no item is lost or repeated.
`default_nettype none

module rv32i_instruction_decoder
    import rvdec_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_instr_valid,
    output logic                    o_instr_ready,
    input  wire logic [31:0]        i_instr_word,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output logic [5:0]              o_op_type,
    output logic [6:0]              o_major_opcode,
    output logic [6:0]              o_upper_funct,
    output logic [2:0]              o_minor_funct,
    output logic [4:0]              o_dest_reg,
    output logic [4:0]              o_src_reg_a,
    output logic [4:0]              o_src_reg_b,
    output logic signed [31:0]      o_immediate
);

    logic        r_in_valid;
    logic        n_in_valid;
    logic [31:0] r_word;
    logic        r_out_valid;
    logic        n_out_valid;
    t_dec_result r_res;
    t_dec_result dec_res;
    logic        out_free;
    logic        in_take;

    rvdec_core u_core (
        .i_word (r_word),
        .o_res  (dec_res)
    );

    assign out_free      = !r_out_valid || i_res_ready;
    assign o_instr_ready = !r_in_valid || out_free;
    assign in_take       = i_instr_valid && o_instr_ready;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = r_in_valid;
        end
        if (o_instr_ready) begin
            n_in_valid = i_instr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_word <= i_instr_word;
        end
        if (out_free && r_in_valid) begin
            r_res <= dec_res;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_op_type      = r_res.op_type;
    assign o_major_opcode = r_res.major_opcode;
    assign o_upper_funct  = r_res.upper_funct;
    assign o_minor_funct  = r_res.minor_funct;
    assign o_dest_reg     = r_res.dest_reg;
    assign o_src_reg_a    = r_res.src_reg_a;
    assign o_src_reg_b    = r_res.src_reg_b;
    assign o_immediate    = r_res.immediate;

endmodule

`default_nettype wire

>>> sv/rvdec_core.sv
// Combinational field extraction and classification of one RV32I word.
`default_nettype none

module rvdec_core
    import rvdec_pkg::*;
(
    input  wire logic [31:0] i_word,
    output t_dec_result      o_res
);

    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic [31:0] imm_sh;

    assign opc    = i_word[6:0];
    assign f7     = i_word[31:25];
    assign f3     = i_word[14:12];
    assign rd     = i_word[11:7];
    assign rs1    = i_word[19:15];
    assign rs2    = i_word[24:20];
    assign imm_i  = {{20{i_word[31]}}, i_word[31:20]};
    assign imm_s  = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign imm_b  = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                     i_word[11:8], 1'b0};
    assign imm_j  = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                     i_word[30:21], 1'b0};
    assign imm_u  = i_word & U_MASK;
    assign imm_sh = {27'd0, i_word[24:20]};

    always_comb begin
        o_res.op_type      = OP_UNKNOWN;
        o_res.major_opcode = opc;
        o_res.upper_funct  = f7;
        o_res.minor_funct  = f3;
        o_res.dest_reg     = rd;
        o_res.src_reg_a    = rs1;
        o_res.src_reg_b    = rs2;
        o_res.immediate    = '0;

        unique case (opc)
            OPC_R: begin
                if (f7 == F7_BASE) begin
                    o_res.op_type = r_base_op(f3);
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    o_res.op_type = OP_SUB;
                end else if (f7 == F7_ALT && f3 == F3_SR) begin
                    o_res.op_type = OP_SRA;
                end
            end
            OPC_IARITH: begin
                o_res.src_reg_b = '0;
                if (f3 == F3_SL || f3 == F3_SR) begin
                    o_res.immediate = imm_sh;
                    if (f7 == F7_BASE) begin
                        o_res.op_type = iarith_op(f3);
                    end else if (f7 == F7_ALT && f3 == F3_SR) begin
                        o_res.op_type = OP_SRAI;
                    end
                end else begin
                    o_res.immediate = imm_i;
                    o_res.op_type   = iarith_op(f3);
                    if (f3 == F3_ADD && rd == '0 && rs1 == '0 && imm_i == '0) begin
                        o_res.op_type = OP_NOP;
                    end
                end
            end
            OPC_LOAD: begin
                o_res.src_reg_b = '0;
                o_res.immediate = imm_i;
                o_res.op_type   = load_op(f3);
            end
            OPC_STORE: begin
                o_res.dest_reg  = '0;
                o_res.immediate = imm_s;
                o_res.op_type   = store_op(f3);
            end
            OPC_BRANCH: begin
                o_res.dest_reg  = '0;
                o_res.immediate = imm_b;
                o_res.op_type   = branch_op(f3);
            end
            OPC_JAL: begin
                o_res.src_reg_a = '0;
                o_res.src_reg_b = '0;
                o_res.immediate = imm_j;
                o_res.op_type   = OP_JAL;
            end
            OPC_JALR: begin
                o_res.src_reg_b = '0;
                o_res.immediate = imm_i;
                o_res.op_type   = (f3 == F3_ADD) ? OP_JALR : OP_UNKNOWN;
            end
            OPC_AUIPC: begin
                o_res.src_reg_a = '0;
                o_res.src_reg_b = '0;
                o_res.immediate = imm_u;
                o_res.op_type   = OP_AUIPC;
            end
            OPC_LUI: begin
                o_res.src_reg_a = '0;
                o_res.src_reg_b = '0;
                o_res.immediate = imm_u;
                o_res.op_type   = OP_LUI;
            end
            default: begin
                o_res.op_type = OP_UNKNOWN;
            end
        endcase

        if (i_word == HALT_WORD) begin
            o_res.op_type      = OP_HALT;
            o_res.major_opcode = '0;
            o_res.upper_funct  = '0;
            o_res.minor_funct  = '0;
            o_res.dest_reg     = '0;
            o_res.src_reg_a    = '0;
            o_res.src_reg_b    = '0;
            o_res.immediate    = HALT_IMM;
        end
    end

endmodule

`default_nettype wire

>>> sv/rvdec_checker.sv
// Port-level checks for the RV32I decoder, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module rvdec_checker
    import rvdec_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               o_res_valid,
    input  wire logic               i_res_ready,
    input  wire logic [5:0]         o_op_type,
    input  wire logic [6:0]         o_major_opcode,
    input  wire logic [4:0]         o_dest_reg,
    input  wire logic [4:0]         o_src_reg_a,
    input  wire logic [4:0]         o_src_reg_b,
    input  wire logic signed [31:0] o_immediate
);

    logic        halt_out;
    logic        halt_fields_zero;
    logic        r_type_out;
    logic        res_stalled;
    logic [38:0] res_bits;

    assign halt_out         = o_res_valid && o_op_type == OP_HALT;
    assign halt_fields_zero = o_major_opcode == '0 && o_dest_reg == '0 && o_src_reg_a == '0 &&
                              o_src_reg_b == '0 && o_immediate == HALT_IMM;
    assign r_type_out       = o_res_valid && o_major_opcode == OPC_R;
    assign res_stalled      = o_res_valid && !i_res_ready;
    assign res_bits         = {o_res_valid, o_op_type, o_immediate};

    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_res_valid, "result valid after reset")

    `ASSERT_CLK(a_halt_fields, i_clk, i_rst_n, halt_out |-> halt_fields_zero, "halt fields wrong")

    `ASSERT_CLK(a_r_no_imm, i_clk, i_rst_n, r_type_out |-> o_immediate == '0, "R with immediate")

    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, res_stalled |=> $stable(res_bits), "stall changed")

endmodule

bind rv32i_instruction_decoder rvdec_checker u_rvdec_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_res_valid    (o_res_valid),
    .i_res_ready    (i_res_ready),
    .o_op_type      (o_op_type),
    .o_major_opcode (o_major_opcode),
    .o_dest_reg     (o_dest_reg),
    .o_src_reg_a    (o_src_reg_a),
    .o_src_reg_b    (o_src_reg_b),
    .o_immediate    (o_immediate)
);

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the RV32I instruction decoder: directed and random words.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rvdec_pkg::*;

    localparam logic [2:0] F3_SLT    = 3'd2;
    localparam logic [2:0] F3_SLTU   = 3'd3;
    localparam logic [2:0] F3_XOR    = 3'd4;
    localparam logic [2:0] F3_OR     = 3'd6;
    localparam logic [2:0] F3_AND    = 3'd7;
    localparam logic [2:0] F3_BYTE   = 3'd0;
    localparam logic [2:0] F3_HALF   = 3'd1;
    localparam logic [2:0] F3_WORD   = 3'd2;
    localparam logic [2:0] F3_BYTE_U = 3'd4;
    localparam logic [2:0] F3_HALF_U = 3'd5;
    localparam logic [2:0] F3_BEQ    = 3'd0;
    localparam logic [2:0] F3_BNE    = 3'd1;
    localparam logic [2:0] F3_BLT    = 3'd4;
    localparam logic [2:0] F3_BGE    = 3'd5;
    localparam logic [2:0] F3_BLTU   = 3'd6;
    localparam logic [2:0] F3_BGEU   = 3'd7;

    localparam int RANDOM_ITEMS = 1350;
    localparam int STALL_LIMIT  = 400;
    localparam int MAX_REPORTS  = 100;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_instr_valid;
    logic               o_instr_ready;
    logic [31:0]        i_instr_word;
    logic               o_res_valid;
    logic               i_res_ready;
    logic [5:0]         o_op_type;
    logic [6:0]         o_major_opcode;
    logic [6:0]         o_upper_funct;
    logic [2:0]         o_minor_funct;
    logic [4:0]         o_dest_reg;
    logic [4:0]         o_src_reg_a;
    logic [4:0]         o_src_reg_b;
    logic signed [31:0] o_immediate;

    t_dec_result pending_decodes[$];
    t_dec_result want;
    int          err_count = 0;
    int          stall_cycles = 0;
    bit          idle_en = 1'b1;

    rv32i_instruction_decoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_instr_valid  (i_instr_valid),
        .o_instr_ready  (o_instr_ready),
        .i_instr_word   (i_instr_word),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_op_type      (o_op_type),
        .o_major_opcode (o_major_opcode),
        .o_upper_funct  (o_upper_funct),
        .o_minor_funct  (o_minor_funct),
        .o_dest_reg     (o_dest_reg),
        .o_src_reg_a    (o_src_reg_a),
        .o_src_reg_b    (o_src_reg_b),
        .o_immediate    (o_immediate)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [31:0] pack_word(input logic [6:0] f7, input logic [4:0] rs2,
                                              input logic [4:0] rs1, input logic [2:0] f3,
                                              input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic t_dec_result decode_instr(input logic [31:0] w);
        t_dec_result r;
        logic [6:0]  f7;
        logic [2:0]  f3;
        f7 = w[31:25];
        f3 = w[14:12];
        r.op_type      = OP_UNKNOWN;
        r.major_opcode = w[6:0];
        r.upper_funct  = f7;
        r.minor_funct  = f3;
        r.dest_reg     = w[11:7];
        r.src_reg_a    = w[19:15];
        r.src_reg_b    = w[24:20];
        r.immediate    = '0;
        if (w == HALT_WORD) begin
            r = '0;
            r.op_type   = OP_HALT;
            r.immediate = HALT_IMM;
            return r;
        end
        case (w[6:0])
            OPC_R: begin
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD:  r.op_type = OP_ADD;
                        F3_SL:   r.op_type = OP_SLL;
                        F3_SLT:  r.op_type = OP_SLT;
                        F3_SLTU: r.op_type = OP_SLTU;
                        F3_XOR:  r.op_type = OP_XOR;
                        F3_SR:   r.op_type = OP_SRL;
                        F3_OR:   r.op_type = OP_OR;
                        default: r.op_type = OP_AND;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    r.op_type = OP_SUB;
                end else if (f7 == F7_ALT && f3 == F3_SR) begin
                    r.op_type = OP_SRA;
                end
            end
            OPC_IARITH: begin
                r.src_reg_b = '0;
                r.immediate = {{20{w[31]}}, w[31:20]};
                case (f3)
                    F3_ADD:  r.op_type = OP_ADDI;
                    F3_SLT:  r.op_type = OP_SLTI;
                    F3_SLTU: r.op_type = OP_SLTIU;
                    F3_XOR:  r.op_type = OP_XORI;
                    F3_OR:   r.op_type = OP_ORI;
                    F3_AND:  r.op_type = OP_ANDI;
                    default: begin
                        r.immediate = {27'd0, w[24:20]};
                        if (f7 == F7_BASE) begin
                            r.op_type = (f3 == F3_SL) ? OP_SLLI : OP_SRLI;
                        end else if (f7 == F7_ALT && f3 == F3_SR) begin
                            r.op_type = OP_SRAI;
                        end
                    end
                endcase
                if (r.op_type == OP_ADDI && r.dest_reg == '0 && r.src_reg_a == '0 &&
                    r.immediate == '0) begin
                    r.op_type = OP_NOP;
                end
            end
            OPC_LOAD: begin
                r.src_reg_b = '0;
                r.immediate = {{20{w[31]}}, w[31:20]};
                case (f3)
                    F3_BYTE:   r.op_type = OP_LB;
                    F3_HALF:   r.op_type = OP_LH;
                    F3_WORD:   r.op_type = OP_LW;
                    F3_BYTE_U: r.op_type = OP_LBU;
                    F3_HALF_U: r.op_type = OP_LHU;
                    default:   r.op_type = OP_UNKNOWN;
                endcase
            end
            OPC_STORE: begin
                r.dest_reg  = '0;
                r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
                case (f3)
                    F3_BYTE: r.op_type = OP_SB;
                    F3_HALF: r.op_type = OP_SH;
                    F3_WORD: r.op_type = OP_SW;
                    default: r.op_type = OP_UNKNOWN;
                endcase
            end
            OPC_BRANCH: begin
                r.dest_reg  = '0;
                r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                case (f3)
                    F3_BEQ:  r.op_type = OP_BEQ;
                    F3_BNE:  r.op_type = OP_BNE;
                    F3_BLT:  r.op_type = OP_BLT;
                    F3_BGE:  r.op_type = OP_BGE;
                    F3_BLTU: r.op_type = OP_BLTU;
                    F3_BGEU: r.op_type = OP_BGEU;
                    default: r.op_type = OP_UNKNOWN;
                endcase
            end
            OPC_JAL: begin
                r.src_reg_a = '0;
                r.src_reg_b = '0;
                r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                r.op_type   = OP_JAL;
            end
            OPC_JALR: begin
                r.src_reg_b = '0;
                r.immediate = {{20{w[31]}}, w[31:20]};
                r.op_type   = (f3 == F3_ADD) ? OP_JALR : OP_UNKNOWN;
            end
            OPC_AUIPC: begin
                r.src_reg_a = '0;
                r.src_reg_b = '0;
                r.immediate = w & U_MASK;
                r.op_type   = OP_AUIPC;
            end
            OPC_LUI: begin
                r.src_reg_a = '0;
                r.src_reg_b = '0;
                r.immediate = w & U_MASK;
                r.op_type   = OP_LUI;
            end
            default: r.op_type = OP_UNKNOWN;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        int          pick;
        w    = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            return HALT_WORD;
        end
        if (pick < 6) begin
            return pack_word(F7_BASE, '0, '0, F3_ADD, '0, OPC_IARITH);
        end
        if (pick < 14) begin
            return w;
        end
        case ($urandom_range(0, 8))
            0:       w[6:0] = OPC_R;
            1:       w[6:0] = OPC_IARITH;
            2:       w[6:0] = OPC_LOAD;
            3:       w[6:0] = OPC_STORE;
            4:       w[6:0] = OPC_BRANCH;
            5:       w[6:0] = OPC_JAL;
            6:       w[6:0] = OPC_JALR;
            7:       w[6:0] = OPC_AUIPC;
            default: w[6:0] = OPC_LUI;
        endcase
        if ((w[6:0] == OPC_R || w[6:0] == OPC_IARITH) && $urandom_range(0, 9) < 8) begin
            w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
        end
        if (w[6:0] == OPC_JALR && $urandom_range(0, 3) != 0) begin
            w[14:12] = F3_ADD;
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("mismatch %s: got %h, want %h", what, got, exp_val);
        end
    endtask

    task automatic send_item(input logic [31:0] w);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_instr_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pending_decodes.push_back(decode_instr(w));
        i_instr_valid <= 1'b1;
        i_instr_word  <= w;
        @(posedge i_clk);
        while (!o_instr_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_special_words();
        send_item(HALT_WORD);
        send_item(pack_word(F7_BASE, '0, '0, F3_ADD, '0, OPC_IARITH));
        send_item(pack_word(F7_BASE, 5'd1, '0, F3_ADD, '0, OPC_IARITH));
        send_item(pack_word(F7_BASE, '0, 5'd1, F3_ADD, '0, OPC_IARITH));
        send_item(HALT_WORD ^ 32'h0000_0080);
    endtask

    task automatic test_register_ops();
        send_item(pack_word(F7_BASE, '0, '0, F3_ADD, '0, OPC_R));
        send_item(pack_word(F7_ALT, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_R));
        send_item(pack_word(F7_ALT, 5'd7, 5'd9, F3_SR, 5'd3, OPC_R));
        send_item(pack_word(~F7_BASE, 5'd31, '0, F3_AND, 5'd31, OPC_R));
        send_item(pack_word(F7_ALT, 5'd1, 5'd2, F3_SLT, 5'd4, OPC_R));
    endtask

    task automatic test_immediate_ops();
        send_item(pack_word(F7_BASE, 5'd31, 5'd1, F3_SL, 5'd2, OPC_IARITH));
        send_item(pack_word(F7_ALT, 5'd31, 5'd31, F3_SR, 5'd31, OPC_IARITH));
        send_item(pack_word(F7_ALT, 5'd3, 5'd3, F3_SL, 5'd3, OPC_IARITH));
        send_item(pack_word(7'h40, '0, 5'd5, F3_ADD, 5'd6, OPC_IARITH));
        send_item(pack_word(7'h3F, 5'd31, 5'd7, F3_AND, 5'd8, OPC_IARITH));
    endtask

    task automatic test_memory_ops();
        send_item(pack_word(7'h7F, 5'd31, 5'd31, F3_WORD, 5'd31, OPC_LOAD));
        send_item(pack_word(F7_BASE, 5'd4, 5'd2, F3_SLTU, 5'd1, OPC_LOAD));
        send_item(pack_word(7'h40, '0, 5'd1, F3_WORD, '0, OPC_STORE));
        send_item(pack_word(7'h3F, 5'd31, 5'd31, F3_AND, 5'd31, OPC_STORE));
    endtask

    task automatic test_control_ops();
        send_item(pack_word(7'h7F, 5'd31, 5'd31, F3_BEQ, 5'd31, OPC_BRANCH));
        send_item(pack_word(F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd30, OPC_BRANCH));
        send_item({25'h1FF_FFFF, OPC_JAL});
        send_item({25'd0, OPC_JAL});
        send_item(pack_word(7'h7F, 5'd31, 5'd1, F3_ADD, 5'd1, OPC_JALR));
        send_item(pack_word(F7_BASE, '0, 5'd1, F3_SL, 5'd1, OPC_JALR));
        send_item({20'hFFFFF, 5'd31, OPC_AUIPC});
        send_item({25'd0, OPC_LUI});
    endtask

    task automatic test_unknown_opcodes();
        send_item(32'hFFFF_FFFF);
        send_item(32'h0000_0000);
    endtask

    task automatic test_random_stream();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_en = !((i >= 400 && i < 500) || i >= RANDOM_ITEMS - 150);
            send_item(random_word());
        end
    endtask

    task automatic finish_run();
        i_instr_valid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_instr_valid = 1'b0;
        i_instr_word  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_special_words();
        test_register_ops();
        test_immediate_ops();
        test_memory_ops();
        test_control_ops();
        test_unknown_opcodes();
        test_random_stream();
        finish_run();
    end

    initial begin
        int burst;
        i_res_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 15);
                i_res_ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_decodes.size() == 0) begin
                report_mismatch("unexpected result op_type", {26'd0, o_op_type}, '0);
            end else begin
                want = pending_decodes.pop_front();
                if (o_op_type !== want.op_type)
                    report_mismatch("op_type", {26'd0, o_op_type}, {26'd0, want.op_type});
                if (o_major_opcode !== want.major_opcode)
                    report_mismatch("major_opcode", {25'd0, o_major_opcode},
                                    {25'd0, want.major_opcode});
                if (o_upper_funct !== want.upper_funct)
                    report_mismatch("upper_funct", {25'd0, o_upper_funct},
                                    {25'd0, want.upper_funct});
                if (o_minor_funct !== want.minor_funct)
                    report_mismatch("minor_funct", {29'd0, o_minor_funct},
                                    {29'd0, want.minor_funct});
                if (o_dest_reg !== want.dest_reg)
                    report_mismatch("dest_reg", {27'd0, o_dest_reg}, {27'd0, want.dest_reg});
                if (o_src_reg_a !== want.src_reg_a)
                    report_mismatch("src_reg_a", {27'd0, o_src_reg_a}, {27'd0, want.src_reg_a});
                if (o_src_reg_b !== want.src_reg_b)
                    report_mismatch("src_reg_b", {27'd0, o_src_reg_b}, {27'd0, want.src_reg_b});
                if (o_immediate !== want.immediate)
                    report_mismatch("immediate", o_immediate, want.immediate);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_instr_valid && o_instr_ready) || (o_res_valid && i_res_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
